// File: rtl/ute_pkg.sv
// Shared types, codes and character tables for the URL template expander.
`default_nettype none
package ute_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 32;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned PAD_W   = 2;

	localparam logic [BYTE_W-1:0] OP_FIRST = 8'd128;
	localparam logic [BYTE_W-1:0] OP_LIMIT = 8'd134;

	localparam logic [OP_W-1:0] OP_B32_ALL = 3'd0;
	localparam logic [OP_W-1:0] OP_B64     = 3'd5;

	localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_THREE   = 8'h33;
	localparam logic [BYTE_W-1:0] CH_UPPER_D = 8'h44;
	localparam logic [BYTE_W-1:0] CH_DASH    = 8'h2D;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BADOP = 2'd1,
		ST_TRUNC = 2'd2
	} status_t;

	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] ch;
		logic              eol;
	} emit_t;

	typedef struct packed {
		logic              vld;
		logic [OP_W-1:0]   op;
		logic              last;
	} start_t;

	function automatic logic [BYTE_W-1:0] b32hex_char(input logic [4:0] v);
		logic [BYTE_W-1:0] ext;
		ext = {3'b000, v};
		if (v < 5'd10) begin
			return ext + 8'h30;
		end
		return ext + 8'h37;
	endfunction

	function automatic logic [BYTE_W-1:0] b64url_char(input logic [5:0] v);
		logic [BYTE_W-1:0] ext;
		ext = {2'b00, v};
		if (v < 6'd26) begin
			return ext + 8'h41;
		end else if (v < 6'd52) begin
			return ext + 8'h47;
		end else if (v < 6'd62) begin
			return ext - 8'd4;
		end else if (v == 6'd62) begin
			return CH_DASH;
		end
		return CH_UNDER;
	endfunction

	// Argument is the kept byte count minus one.
	function automatic logic [CNT_W-1:0] len_b32(input logic [1:0] nm1);
		logic [CNT_W-1:0] r;
		unique case (nm1)
			2'd0:    r = 3'd2;
			2'd1:    r = 3'd4;
			2'd2:    r = 3'd5;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] len_b64(input logic [1:0] nm1);
		logic [CNT_W-1:0] r;
		unique case (nm1)
			2'd0:    r = 3'd2;
			2'd1:    r = 3'd3;
			2'd2:    r = 3'd4;
			default: r = 3'd6;
		endcase
		return r;
	endfunction

	function automatic logic [PAD_W-1:0] pad_b64(input logic [1:0] nm1);
		logic [PAD_W-1:0] r;
		unique case (nm1)
			2'd0:    r = 2'd2;
			2'd1:    r = 2'd1;
			2'd2:    r = 2'd0;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/url_template_expander_top.sv
// Top level of the URL template expander: template parsing, output register, config.
// A literal byte's result is registered in the output register when the byte is transferred.
// Flow control: literal and count bytes are accepted whenever the output register has room; an
// expansion opcode then holds the input while each character is emitted (up to 12) and while
// the shared shifter steps to the selected character of the single-character forms.
// Reset: arst_n clears the sequencer, output valid, run count, error flag and patch_index.
`default_nettype none
module url_template_expander_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [ute_pkg::INDEX_W-1:0]      cfg_wdata,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [ute_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] template_byte
	input  wire                              s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [ute_pkg::BYTE_W-1:0]       m_axis_tdata,  // [7:0] url_char
	output logic                             m_axis_tlast,
	output logic [1:0]                       m_axis_tuser   // [1:0] status
);

	logic [ute_pkg::INDEX_W-1:0]   patch_index_q;
	logic [ute_pkg::COUNT_W-1:0]   lit_left_q;
	logic                          err_seen_q;
	logic                          out_vld_q;
	logic [ute_pkg::BYTE_W-1:0]    out_ch_q;
	logic                          out_eol_q;
	ute_pkg::status_t              out_st_q;

	logic                          slot_free;
	logic                          exp_busy;
	logic                          acc_in;
	ute_pkg::start_t               start;
	ute_pkg::emit_t                emit;

	logic                          p_vld;
	logic [ute_pkg::BYTE_W-1:0]    p_ch;
	logic                          p_eol;
	ute_pkg::status_t              p_st;
	logic [ute_pkg::COUNT_W-1:0]   lit_dec;
	logic [ute_pkg::COUNT_W-1:0]   lit_d;
	logic                          err_d;

	assign slot_free     = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !exp_busy && slot_free;
	assign acc_in        = s_axis_tvalid && s_axis_tready;
	assign lit_dec       = lit_left_q - 7'd1;

	always_comb begin
		p_vld      = 1'b0;
		p_ch       = '0;
		p_eol      = 1'b1;
		p_st       = ute_pkg::ST_OK;
		lit_d      = lit_left_q;
		err_d      = err_seen_q;
		start.vld  = 1'b0;
		start.op   = s_axis_tdata[ute_pkg::OP_W-1:0];
		start.last = s_axis_tlast;
		if (acc_in) begin
			if (err_seen_q) begin
				if (s_axis_tlast) begin
					err_d = 1'b0;
					lit_d = '0;
				end
			end else if (lit_left_q != '0) begin
				p_vld = 1'b1;
				if (s_axis_tlast && (lit_dec != '0)) begin
					lit_d = '0;
					p_st  = ute_pkg::ST_TRUNC;
				end else begin
					lit_d = lit_dec;
					p_ch  = s_axis_tdata;
					p_eol = s_axis_tlast;
				end
			end else if (s_axis_tdata < ute_pkg::OP_FIRST) begin
				if (s_axis_tdata[ute_pkg::COUNT_W-1:0] == '0) begin
					p_vld = 1'b1;
					p_st  = ute_pkg::ST_BADOP;
					err_d = !s_axis_tlast;
				end else if (s_axis_tlast) begin
					p_vld = 1'b1;
					p_st  = ute_pkg::ST_TRUNC;
				end else begin
					lit_d = s_axis_tdata[ute_pkg::COUNT_W-1:0];
				end
			end else if (s_axis_tdata >= ute_pkg::OP_LIMIT) begin
				p_vld = 1'b1;
				p_st  = ute_pkg::ST_BADOP;
				err_d = !s_axis_tlast;
			end else begin
				start.vld = 1'b1;
			end
		end
	end

	ute_expand u_expand (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.patch_index (patch_index_q),
		.step        (slot_free),
		.busy        (exp_busy),
		.emit        (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_index_q <= '0;
			lit_left_q    <= '0;
			err_seen_q    <= 1'b0;
			out_vld_q     <= 1'b0;
			out_ch_q      <= '0;
			out_eol_q     <= 1'b0;
			out_st_q      <= ute_pkg::ST_OK;
		end else begin
			if (cfg_we) begin
				patch_index_q <= cfg_wdata;
			end
			lit_left_q <= lit_d;
			err_seen_q <= err_d;
			if (p_vld) begin
				out_vld_q <= 1'b1;
				out_ch_q  <= p_ch;
				out_eol_q <= p_eol;
				out_st_q  <= p_st;
			end else if (emit.vld) begin
				out_vld_q <= 1'b1;
				out_ch_q  <= emit.ch;
				out_eol_q <= emit.eol;
				out_st_q  <= ute_pkg::ST_OK;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_ch_q;
	assign m_axis_tlast  = out_eol_q;
	assign m_axis_tuser  = out_st_q;

endmodule
`default_nettype wire

// File: rtl/ute_expand.sv
// Expansion sequencer: one shared shifter walks the index and emits at most one character a step.
`default_nettype none
module ute_expand (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  ute_pkg::start_t                     start,
	input  wire  [ute_pkg::INDEX_W-1:0]         patch_index,
	input  wire                                 step,
	output logic                                busy,
	output ute_pkg::emit_t                      emit
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SKIP,
		S_CHAR,
		S_PAD,
		S_UNDER
	} state_t;

	state_t                          state_q;
	logic [ute_pkg::INDEX_W-1:0]     acc_q;
	logic                            w6_q;
	logic [ute_pkg::CNT_W-1:0]       chars_q;
	logic [ute_pkg::CNT_W-1:0]       skip_q;
	logic [ute_pkg::PAD_W-1:0]       pad_q;
	logic [1:0]                      ppos_q;
	logic                            last_q;

	logic [1:0]                      nm1;
	logic [ute_pkg::INDEX_W-1:0]     aligned;
	logic [ute_pkg::CNT_W-1:0]       l32;
	logic [ute_pkg::INDEX_W-1:0]     shifted;
	logic [ute_pkg::BYTE_W-1:0]      alpha;
	logic [ute_pkg::BYTE_W-1:0]      pad_ch;
	logic                            fin;

	always_comb begin
		if (patch_index[31:24] != 8'd0) begin
			nm1 = 2'd3;
		end else if (patch_index[23:16] != 8'd0) begin
			nm1 = 2'd2;
		end else if (patch_index[15:8] != 8'd0) begin
			nm1 = 2'd1;
		end else begin
			nm1 = 2'd0;
		end
		unique case (nm1)
			2'd0:    aligned = {patch_index[7:0], 24'd0};
			2'd1:    aligned = {patch_index[15:0], 16'd0};
			2'd2:    aligned = {patch_index[23:0], 8'd0};
			default: aligned = patch_index;
		endcase
		l32 = ute_pkg::len_b32(nm1);
	end

	assign shifted = w6_q ? {acc_q[25:0], 6'd0} : {acc_q[26:0], 5'd0};
	assign alpha   = w6_q ? ute_pkg::b64url_char(acc_q[31:26])
	                      : ute_pkg::b32hex_char(acc_q[31:27]);

	always_comb begin
		unique case (ppos_q)
			2'd0:    pad_ch = ute_pkg::CH_PERCENT;
			2'd1:    pad_ch = ute_pkg::CH_THREE;
			default: pad_ch = ute_pkg::CH_UPPER_D;
		endcase
	end

	always_comb begin
		emit = '0;
		fin  = 1'b0;
		if (step) begin
			unique case (state_q)
				S_CHAR: begin
					emit.vld = 1'b1;
					emit.ch  = alpha;
					fin      = (chars_q == 3'd1) && (pad_q == 2'd0);
				end
				S_PAD: begin
					emit.vld = 1'b1;
					emit.ch  = pad_ch;
					fin      = (pad_q == 2'd1) && (ppos_q == 2'd2);
				end
				S_UNDER: begin
					emit.vld = 1'b1;
					emit.ch  = ute_pkg::CH_UNDER;
					fin      = 1'b1;
				end
				default: begin
					emit = '0;
				end
			endcase
		end
		emit.eol = emit.vld && fin && last_q;
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chars_q <= '0;
			skip_q  <= '0;
			pad_q   <= '0;
			ppos_q  <= '0;
			last_q  <= 1'b0;
			w6_q    <= 1'b0;
			acc_q   <= '0;
		end else if (start.vld) begin
			acc_q  <= aligned;
			last_q <= start.last;
			ppos_q <= 2'd0;
			pad_q  <= 2'd0;
			skip_q <= 3'd0;
			w6_q   <= 1'b0;
			if (start.op == ute_pkg::OP_B32_ALL) begin
				chars_q <= l32;
				state_q <= S_CHAR;
			end else if (start.op == ute_pkg::OP_B64) begin
				w6_q    <= 1'b1;
				chars_q <= ute_pkg::len_b64(nm1);
				pad_q   <= ute_pkg::pad_b64(nm1);
				state_q <= S_CHAR;
			end else if (l32 >= start.op) begin
				chars_q <= 3'd1;
				skip_q  <= l32 - start.op;
				state_q <= (l32 == start.op) ? S_CHAR : S_SKIP;
			end else begin
				state_q <= S_UNDER;
			end
		end else if (step) begin
			unique case (state_q)
				S_IDLE: begin
					state_q <= S_IDLE;
				end
				S_SKIP: begin
					acc_q  <= shifted;
					skip_q <= skip_q - 3'd1;
					if (skip_q == 3'd1) begin
						state_q <= S_CHAR;
					end
				end
				S_CHAR: begin
					acc_q   <= shifted;
					chars_q <= chars_q - 3'd1;
					if (chars_q == 3'd1) begin
						state_q <= (pad_q != 2'd0) ? S_PAD : S_IDLE;
					end
				end
				S_PAD: begin
					if (ppos_q == 2'd2) begin
						ppos_q <= 2'd0;
						pad_q  <= pad_q - 2'd1;
						if (pad_q == 2'd1) begin
							state_q <= S_IDLE;
						end
					end else begin
						ppos_q <= ppos_q + 2'd1;
					end
				end
				S_UNDER: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit.vld |-> busy)
		else $error("character emitted while sequencer idle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start.vld |-> !busy)
		else $error("expansion started while sequencer busy");
	a_eol_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.vld && emit.eol) |=> !busy)
		else $error("sequencer still busy after end of URL");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.vld && fin) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after final character");
`endif

endmodule
`default_nettype wire
